[rtl/rtp_h264_fu_a_depacketizer_top_assert.svh]
`ifndef RTP_H264_FU_A_DEPACKETIZER_TOP_ASSERT_SVH
`define RTP_H264_FU_A_DEPACKETIZER_TOP_ASSERT_SVH

// Checked outside reset.
`define RTPFU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define RTPFU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/rtpfu_pkg.sv]
`default_nettype none

package rtpfu_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       datagram_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] item_kind;
    logic [2:0] packet_status;
    logic       frame_done;
    logic       sequence_jump;
    logic       marker_mismatch;
    logic       run_last;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_DISCARD = 2'd1,
    KIND_REPORT  = 2'd2
  } item_kind_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FIRST  = 3'd1,
    ST_PTYPE  = 3'd2,
    ST_SOURCE = 3'd3,
    ST_TRUNC  = 3'd4
  } status_e;

  typedef enum logic {
    CFG_PAYLOAD_TYPE = 1'b0,
    CFG_SOURCE_ID    = 1'b1
  } cfg_index_e;

  // Work for one input byte, expanded by the back end in this order:
  // discard, start code, data byte, report.
  typedef struct packed {
    logic       discard;
    logic       prefix;
    logic       data_en;
    logic [7:0] data_byte;
    logic       report_en;
    logic [2:0] status;
    logic       done;
    logic       jump;
    logic       mis;
  } cmd_t;

  localparam int unsigned NUM_SLOTS    = 7;
  localparam int unsigned SLOT_DISCARD = 0;
  localparam int unsigned SLOT_PFX0    = 1;
  localparam int unsigned SLOT_PFX1    = 2;
  localparam int unsigned SLOT_PFX2    = 3;
  localparam int unsigned SLOT_PFX3    = 4;
  localparam int unsigned SLOT_DATA    = 5;
  localparam int unsigned SLOT_REPORT  = 6;

  localparam logic [7:0]  FIRST_BYTE     = 8'h80;
  localparam logic [4:0]  FU_TYPE        = 5'd28;
  localparam logic [6:0]  PT_RESET       = 7'd96;
  localparam logic [31:0] SOURCE_RESET   = 32'h7845_7845;
  localparam logic [7:0]  START_CODE_END = 8'h01;

  localparam logic [3:0] POS_FIRST  = 4'd0;
  localparam logic [3:0] POS_PTYPE  = 4'd1;
  localparam logic [3:0] POS_SEQ_HI = 4'd2;
  localparam logic [3:0] POS_SEQ_LO = 4'd3;
  localparam logic [3:0] POS_SRC_HI = 4'd8;
  localparam logic [3:0] POS_SRC_LO = 4'd11;
  localparam logic [3:0] POS_NAL    = 4'd12;
  localparam logic [3:0] POS_FU_HDR = 4'd13;
  localparam logic [3:0] POS_MAX    = 4'd14;

endpackage

`default_nettype wire

[rtl/rtpfu_front.sv]
`default_nettype none

`include "rtp_h264_fu_a_depacketizer_top_assert.svh"

module rtpfu_front
  import rtpfu_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  input  wire logic     cfg_we_i,
  input  wire logic     cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic     q_full_i,
  output logic          cmd_push_o,
  output cmd_t          cmd_o
);

  logic [6:0]  pt_q;
  logic [31:0] src_id_q;
  logic [3:0]  pos_q, pos_d;
  logic [2:0]  perr_q, perr_d;
  logic        marker_q, marker_d;
  logic [15:0] seq_q, seq_d;
  logic [15:0] prev_q, prev_d;
  logic        srcmis_q, srcmis_d;
  logic        frag_q, frag_d;
  logic [1:0]  imp_q, imp_d;
  logic        fend_q, fend_d;
  logic        fopen_q, fopen_d;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic [7:0]  want;
  logic        data_req;
  logic [7:0]  data_val;
  logic        accepted;
  logic        headers;
  cmd_t        cmd;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign b          = in_data_i.in_byte;
  assign last       = in_data_i.datagram_end;

  always_comb begin
    unique case (pos_q[1:0])
      2'd0:    want = src_id_q[31:24];
      2'd1:    want = src_id_q[23:16];
      2'd2:    want = src_id_q[15:8];
      default: want = src_id_q[7:0];
    endcase
  end

  always_comb begin
    pos_d    = pos_q;
    perr_d   = perr_q;
    marker_d = marker_q;
    seq_d    = seq_q;
    prev_d   = prev_q;
    srcmis_d = srcmis_q;
    frag_d   = frag_q;
    imp_d    = imp_q;
    fend_d   = fend_q;
    fopen_d  = fopen_q;
    data_req = 1'b0;
    data_val = 8'h00;
    accepted = 1'b0;
    headers  = 1'b0;
    cmd      = '0;

    if (perr_q == ST_OK) begin
      priority if (pos_q == POS_FIRST) begin
        if (b != FIRST_BYTE) perr_d = ST_FIRST;
      end else if (pos_q == POS_PTYPE) begin
        marker_d = b[7];
        if (b[6:0] != pt_q) perr_d = ST_PTYPE;
      end else if (pos_q == POS_SEQ_HI) begin
        seq_d = {b, 8'h00};
      end else if (pos_q == POS_SEQ_LO) begin
        seq_d = seq_q | {8'h00, b};
      end else if (pos_q >= POS_SRC_HI && pos_q <= POS_SRC_LO) begin
        srcmis_d = srcmis_q || (b != want);
        if (pos_q == POS_SRC_LO && srcmis_d) perr_d = ST_SOURCE;
      end else if (pos_q == POS_NAL) begin
        if (b[4:0] == FU_TYPE) begin
          frag_d = 1'b1;
          imp_d  = b[6:5];
          if (last) perr_d = ST_TRUNC;
        end else begin
          data_req = 1'b1;
          data_val = b;
        end
      end else if (pos_q == POS_FU_HDR && frag_q) begin
        fend_d = b[6];
        if (b[7]) begin
          if (fopen_d) begin
            cmd.discard = 1'b1;
            fopen_d     = 1'b0;
          end
          data_req = 1'b1;
          data_val = {1'b0, imp_q, b[4:0]};
        end
      end else if (pos_q >= POS_FU_HDR) begin
        data_req = 1'b1;
        data_val = b;
      end else begin
        perr_d = perr_q;
      end
    end

    if (data_req) begin
      if (!fopen_d) cmd.prefix = 1'b1;
      fopen_d        = 1'b1;
      cmd.data_en    = 1'b1;
      cmd.data_byte  = data_val;
    end

    if (last) begin
      if (perr_d == ST_OK && pos_q < POS_SRC_LO) perr_d = ST_TRUNC;
      accepted = (perr_d == ST_OK);
      headers  = (pos_q >= POS_SRC_LO) && (perr_d == ST_OK || perr_d == ST_TRUNC);
      if (headers) begin
        cmd.jump = (prev_q != 16'h0000) && (seq_d != 16'(prev_q + 16'd1));
        prev_d   = seq_d;
      end
      cmd.mis = accepted && frag_d && (pos_q >= POS_FU_HDR) && (fend_d != marker_d);
      if (accepted && marker_d) begin
        cmd.done = 1'b1;
        if (!fopen_d) cmd.prefix = 1'b1;
        fopen_d = 1'b0;
      end
      cmd.report_en = 1'b1;
      cmd.status    = perr_d;
      pos_d    = POS_FIRST;
      perr_d   = ST_OK;
      marker_d = 1'b0;
      seq_d    = 16'h0000;
      srcmis_d = 1'b0;
      frag_d   = 1'b0;
      imp_d    = 2'b00;
      fend_d   = 1'b0;
    end else begin
      pos_d = (pos_q < POS_MAX) ? 4'(pos_q + 4'd1) : POS_MAX;
    end
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = accept && (cmd.discard || cmd.prefix || cmd.data_en || cmd.report_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q     <= PT_RESET;
      src_id_q <= SOURCE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PAYLOAD_TYPE: pt_q     <= cfg_data_i[6:0];
        CFG_SOURCE_ID:    src_id_q <= cfg_data_i;
        default:          pt_q     <= pt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_FIRST;
      perr_q   <= ST_OK;
      marker_q <= 1'b0;
      seq_q    <= 16'h0000;
      prev_q   <= 16'h0000;
      srcmis_q <= 1'b0;
      frag_q   <= 1'b0;
      imp_q    <= 2'b00;
      fend_q   <= 1'b0;
      fopen_q  <= 1'b0;
    end else if (accept) begin
      pos_q    <= pos_d;
      perr_q   <= perr_d;
      marker_q <= marker_d;
      seq_q    <= seq_d;
      prev_q   <= prev_d;
      srcmis_q <= srcmis_d;
      frag_q   <= frag_d;
      imp_q    <= imp_d;
      fend_q   <= fend_d;
      fopen_q  <= fopen_d;
    end
  end

  `RTPFU_ASSERT(a_pos_clears_at_end, accept && last |=> pos_q == POS_FIRST, "position not cleared after datagram end")
  `RTPFU_ASSERT(a_end_gives_report, accept && last |-> cmd_push_o && cmd_o.report_en, "datagram end without report")
  `RTPFU_ASSERT(a_error_skips_data, perr_q != ST_OK |-> !cmd_o.data_en && !cmd_o.discard, "payload from rejected packet")

endmodule

`default_nettype wire

[rtl/rtpfu_queue.sv]
`default_nettype none

`include "rtp_h264_fu_a_depacketizer_top_assert.svh"

module rtpfu_queue
  import rtpfu_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t wdata_i,
  input  wire logic pop_i,
  output cmd_t      rdata_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(DEPTH));
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_q <= CntW'(count_q + 1'b1);
      end else if (do_pop && !do_push) begin
        count_q <= CntW'(count_q - 1'b1);
      end
    end
  end

  `RTPFU_ASSERT_ALWAYS(a_count_bound, rst_ni |-> count_q <= CntW'(DEPTH), "queue count past depth")
  `RTPFU_ASSERT(a_no_push_full, push_i |-> !full_o, "push into full queue")
  `RTPFU_ASSERT(a_no_pop_empty, pop_i |-> !empty_o, "pop from empty queue")

endmodule

`default_nettype wire

[rtl/rtpfu_back.sv]
`default_nettype none

`include "rtp_h264_fu_a_depacketizer_top_assert.svh"

module rtpfu_back
  import rtpfu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t cmd_i,
  input  wire logic empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_item_t out_data_o
);

  logic [NUM_SLOTS-1:0] slot_en;
  logic [NUM_SLOTS-1:0] sent_q, sent_d;
  logic [NUM_SLOTS-1:0] remain;
  logic [NUM_SLOTS-1:0] cur;
  logic                 last_item;
  logic                 load_ok;
  logic                 take;
  logic                 out_valid_q;
  out_item_t            out_q;
  out_item_t            item;

  always_comb begin
    slot_en               = '0;
    slot_en[SLOT_DISCARD] = cmd_i.discard;
    slot_en[SLOT_PFX0]    = cmd_i.prefix;
    slot_en[SLOT_PFX1]    = cmd_i.prefix;
    slot_en[SLOT_PFX2]    = cmd_i.prefix;
    slot_en[SLOT_PFX3]    = cmd_i.prefix;
    slot_en[SLOT_DATA]    = cmd_i.data_en;
    slot_en[SLOT_REPORT]  = cmd_i.report_en;
  end

  assign remain    = slot_en & ~sent_q;
  assign cur       = remain & NUM_SLOTS'(~remain + 1'b1);
  assign last_item = ((remain & ~cur) == '0);
  assign load_ok   = !out_valid_q || !out_stall_i;
  assign take      = load_ok && !empty_i;
  assign pop_o     = take && last_item;

  always_comb begin
    item          = '0;
    item.run_last = last_item;
    priority if (cur[SLOT_DISCARD]) begin
      item.item_kind = KIND_DISCARD;
    end else if (cur[SLOT_PFX3]) begin
      item.out_byte = START_CODE_END;
    end else if (cur[SLOT_DATA]) begin
      item.out_byte = cmd_i.data_byte;
    end else if (cur[SLOT_REPORT]) begin
      item.item_kind       = KIND_REPORT;
      item.packet_status   = cmd_i.status;
      item.frame_done      = cmd_i.done;
      item.sequence_jump   = cmd_i.jump;
      item.marker_mismatch = cmd_i.mis;
    end else begin
      item.item_kind = KIND_DATA;
    end
  end

  always_comb begin
    sent_d = sent_q;
    if (take) begin
      sent_d = last_item ? '0 : (sent_q | cur);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sent_q <= sent_d;
      if (load_ok) out_valid_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= item;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RTPFU_ASSERT(a_head_not_empty, !empty_i |-> remain != '0, "queued work with no items left")
  `RTPFU_ASSERT(a_report_is_last,
                out_valid_o && out_data_o.item_kind == KIND_REPORT |-> out_data_o.run_last,
                "report not last item")
  `RTPFU_ASSERT(a_discard_not_last,
                out_valid_o && out_data_o.item_kind == KIND_DISCARD |-> !out_data_o.run_last,
                "discard ended a run")

endmodule

`default_nettype wire

[rtl/rtp_h264_fu_a_depacketizer_top.sv]
// A result is registered in the command queue, then in the output register.
// Throughput: one result per cycle while the output is not stalled; one byte per
// cycle while each byte makes at most one result. A start code adds four output
// items, absorbed by the command queue until it fills.
// Reset: asynchronous, active low; clears parser state and queue, loads the
// register defaults (payload type 96, source id 0x78457845).
`default_nettype none

module rtp_h264_fu_a_depacketizer_top
  import rtpfu_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  cmd_t cmd_push_data;
  cmd_t cmd_head;
  logic cmd_push;
  logic cmd_pop;
  logic q_empty;
  logic q_full;

  rtpfu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_push_data)
  );

  rtpfu_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_push_data),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_head),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  rtpfu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_head),
    .empty_i    (q_empty),
    .pop_o      (cmd_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

[dv/rtp_h264_fu_a_depacketizer_checker.sv]
module rtp_h264_fu_a_depacketizer_checker
  import rtpfu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_data_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [6:0]  want_ptype;
  logic [31:0] want_source;

  logic [3:0]  pos_q;
  status_e     pkt_err;
  logic        marker_q;
  logic [15:0] seq_q;
  logic [15:0] prev_seq;
  logic        src_bad;
  logic        fu_mode;
  logic [1:0]  nri_q;
  logic        fu_end;
  logic        frame_open;

  out_item_t   step_items[NUM_SLOTS];
  int          step_n;
  out_item_t   queued_results[$];
  int          fails = 0;

  task automatic report_failure(string msg);
    $display("%0t ns: %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_failure($sformatf("%s: got %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic emit(item_kind_e kind, logic [7:0] b, status_e st, logic done,
                      logic jump, logic mis);
    out_item_t it;
    it.out_byte        = b;
    it.item_kind       = kind;
    it.packet_status   = st;
    it.frame_done      = done;
    it.sequence_jump   = jump;
    it.marker_mismatch = mis;
    it.run_last        = 1'b0;
    step_items[step_n] = it;
    step_n++;
  endtask

  task automatic emit_start_code();
    emit(KIND_DATA, 8'h00, ST_OK, 1'b0, 1'b0, 1'b0);
    emit(KIND_DATA, 8'h00, ST_OK, 1'b0, 1'b0, 1'b0);
    emit(KIND_DATA, 8'h00, ST_OK, 1'b0, 1'b0, 1'b0);
    emit(KIND_DATA, START_CODE_END, ST_OK, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic emit_payload(logic [7:0] b);
    if (!frame_open) begin
      emit_start_code();
      frame_open = 1'b1;
    end
    emit(KIND_DATA, b, ST_OK, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic depacketize_byte(in_item_t it);
    logic [7:0]  b;
    logic        last;
    logic [3:0]  p;
    logic [31:0] src_shifted;
    logic        jump;
    logic        mis;
    logic        done;
    b      = it.in_byte;
    last   = it.datagram_end;
    p      = pos_q;
    step_n = 0;
    jump   = 1'b0;
    mis    = 1'b0;
    done   = 1'b0;
    if (pkt_err == ST_OK) begin
      if (p == POS_FIRST) begin
        if (b != FIRST_BYTE) pkt_err = ST_FIRST;
      end else if (p == POS_PTYPE) begin
        marker_q = b[7];
        if (b[6:0] != want_ptype) pkt_err = ST_PTYPE;
      end else if (p == POS_SEQ_HI) begin
        seq_q = {b, 8'h00};
      end else if (p == POS_SEQ_LO) begin
        seq_q = seq_q | {8'h00, b};
      end else if (p >= POS_SRC_HI && p <= POS_SRC_LO) begin
        src_shifted = want_source >> (8 * (POS_SRC_LO - p));
        if (b != src_shifted[7:0]) src_bad = 1'b1;
        if (p == POS_SRC_LO && src_bad) pkt_err = ST_SOURCE;
      end else if (p == POS_NAL) begin
        if (b[4:0] == FU_TYPE) begin
          fu_mode = 1'b1;
          nri_q   = b[6:5];
          if (last) pkt_err = ST_TRUNC;
        end else begin
          emit_payload(b);
        end
      end else if (p == POS_FU_HDR && fu_mode) begin
        fu_end = b[6];
        if (b[7]) begin
          // drop the partial frame, then rebuild the NAL header
          if (frame_open) begin
            emit(KIND_DISCARD, 8'h00, ST_OK, 1'b0, 1'b0, 1'b0);
            frame_open = 1'b0;
          end
          emit_payload({1'b0, nri_q, b[4:0]});
        end
      end else if (p >= POS_FU_HDR) begin
        emit_payload(b);
      end
    end

    if (last) begin
      if (pkt_err == ST_OK && p < POS_SRC_LO) pkt_err = ST_TRUNC;
      if (p >= POS_SRC_LO && (pkt_err == ST_OK || pkt_err == ST_TRUNC)) begin
        if (prev_seq != 16'h0000 && seq_q != prev_seq + 16'd1) jump = 1'b1;
        prev_seq = seq_q;
      end
      if (pkt_err == ST_OK && fu_mode && p >= POS_FU_HDR && fu_end != marker_q) begin
        mis = 1'b1;
      end
      if (pkt_err == ST_OK && marker_q) begin
        done = 1'b1;
        if (!frame_open) emit_start_code();
        frame_open = 1'b0;
      end
      emit(KIND_REPORT, 8'h00, pkt_err, done, jump, mis);
      pos_q    = POS_FIRST;
      pkt_err  = ST_OK;
      marker_q = 1'b0;
      seq_q    = '0;
      src_bad  = 1'b0;
      fu_mode  = 1'b0;
      nri_q    = '0;
      fu_end   = 1'b0;
    end else begin
      pos_q = (p < POS_MAX) ? p + 4'd1 : POS_MAX;
    end

    if (step_n > 0) step_items[step_n - 1].run_last = 1'b1;
    for (int i = 0; i < step_n; i++) queued_results.push_back(step_items[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      want_ptype  = PT_RESET;
      want_source = SOURCE_RESET;
      pos_q       = POS_FIRST;
      pkt_err     = ST_OK;
      marker_q    = 1'b0;
      seq_q       = '0;
      prev_seq    = '0;
      src_bad     = 1'b0;
      fu_mode     = 1'b0;
      nri_q       = '0;
      fu_end      = 1'b0;
      frame_open  = 1'b0;
      queued_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (queued_results.size() == 0) begin
          report_failure($sformatf("unexpected result %h", out_data_i));
        end else begin
          want = queued_results.pop_front();
          check_field("out_byte", out_data_i.out_byte, want.out_byte);
          check_field("item_kind", 8'(out_data_i.item_kind), 8'(want.item_kind));
          check_field("packet_status", 8'(out_data_i.packet_status),
                      8'(want.packet_status));
          check_field("frame_done", 8'(out_data_i.frame_done), 8'(want.frame_done));
          check_field("sequence_jump", 8'(out_data_i.sequence_jump),
                      8'(want.sequence_jump));
          check_field("marker_mismatch", 8'(out_data_i.marker_mismatch),
                      8'(want.marker_mismatch));
          check_field("run_last", 8'(out_data_i.run_last), 8'(want.run_last));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PAYLOAD_TYPE: want_ptype  = cfg_data_i[6:0];
          CFG_SOURCE_ID:    want_source = cfg_data_i;
          default:          ;
        endcase
      end
      if (in_valid_i && !in_stall_i) depacketize_byte(in_data_i);
    end
    fail_count_o <= fails;
    pending_o    <= queued_results.size();
  end

endmodule

[dv/tb_rtp_h264_fu_a_depacketizer_top.sv]
module tb_rtp_h264_fu_a_depacketizer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rtpfu_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int HoldCycles  = 300;
  localparam int SettleCycles = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_we_i = 1'b0;
  cfg_index_e  cfg_index_i = CFG_PAYLOAD_TYPE;
  logic [31:0] cfg_data_i = '0;

  int          fail_count;
  int          pending;
  bit          calm = 1'b0;
  bit          hold_request = 1'b0;
  logic [6:0]  cur_ptype = PT_RESET;
  logic [31:0] cur_source = SOURCE_RESET;
  logic [15:0] next_seq = 16'h0001;
  logic [7:0]  dgram[$];

  rtp_h264_fu_a_depacketizer_top u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i
  );

  rtp_h264_fu_a_depacketizer_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i  (in_stall_o),
    .in_data_i,
    .out_valid_i (out_valid_o),
    .out_stall_i,
    .out_data_i  (out_data_o),
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #1 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [15:0] take_seq();
    logic [15:0] s;
    int r;
    r = $urandom_range(99);
    if (r < 6) s = 16'h0000;
    else if (r < 14) s = 16'($urandom);
    else if (r < 17) s = 16'hffff;
    else s = next_seq;
    next_seq = s + 16'd1;
    return s;
  endfunction

  function automatic void put_header(logic [7:0] first, logic marker, logic [6:0] pt,
                                     logic [15:0] seq, logic [31:0] src);
    dgram.delete();
    dgram.push_back(first);
    dgram.push_back({marker, pt});
    dgram.push_back(seq[15:8]);
    dgram.push_back(seq[7:0]);
    repeat (4) dgram.push_back(8'($urandom));
    for (int i = 3; i >= 0; i--) dgram.push_back(src[8*i +: 8]);
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    in_item_t it;
    gap = pick_gap();
    it.in_byte      = b;
    it.datagram_end = last;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_dgram();
    foreach (dgram[i]) send_byte(dgram[i], i == dgram.size() - 1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_index_e idx, logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [6:0] pt, logic [31:0] src);
    write_register(CFG_PAYLOAD_TYPE, {25'($urandom), pt});
    write_register(CFG_SOURCE_ID, src);
    cur_ptype  = pt;
    cur_source = src;
  endtask

  task automatic run_phase(int goal);
    int total;
    int t;
    logic marker;
    logic fin;
    total = 0;
    while (total < goal) begin
      if ($urandom_range(9) < 7) begin
        if ($urandom_range(9) < 4) begin
          marker = ($urandom_range(2) == 0);
          put_header(FIRST_BYTE, marker, cur_ptype, take_seq(), cur_source);
          if ($urandom_range(7) != 0) begin
            do t = $urandom_range(31); while (t == FU_TYPE);
            dgram.push_back({1'($urandom), 2'($urandom), 5'(t)});
            repeat ($urandom_range(6)) dgram.push_back(8'($urandom));
          end
        end else begin
          fin    = ($urandom_range(2) == 0);
          marker = ($urandom_range(6) == 0) ? !fin : fin;
          put_header(FIRST_BYTE, marker, cur_ptype, take_seq(), cur_source);
          dgram.push_back({1'($urandom), 2'($urandom), FU_TYPE});
          dgram.push_back({($urandom_range(2) == 0), fin, 1'($urandom), 5'($urandom)});
          repeat ($urandom_range(8)) dgram.push_back(8'($urandom));
        end
        total += dgram.size();
      end else begin
        put_header(FIRST_BYTE, 1'($urandom), cur_ptype, take_seq(), cur_source);
        repeat ($urandom_range(4)) dgram.push_back(8'($urandom));
        case ($urandom_range(5))
          0: do dgram[0] = 8'($urandom); while (dgram[0] == FIRST_BYTE);
          1: dgram[1] = {dgram[1][7], cur_ptype ^ 7'($urandom_range(127, 1))};
          2: begin
            t = 8 + $urandom_range(3);
            dgram[t] = dgram[t] ^ 8'($urandom_range(255, 1));
          end
          3: begin
            t = $urandom_range(11, 1);
            while (dgram.size() > t) void'(dgram.pop_back());
          end
          4: begin
            while (dgram.size() > 12) void'(dgram.pop_back());
            dgram.push_back({1'($urandom), 2'($urandom), FU_TYPE});
          end
          default: begin
            dgram.delete();
            repeat ($urandom_range(20, 1)) dgram.push_back(8'($urandom));
          end
        endcase
      end
      send_dgram();
    end
  endtask

  initial begin
    int run;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
      run = pick_gap();
      if (run > 0) begin
        out_stall_i <= 1'b1;
        repeat (run) @(posedge clk_i);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dgram = '{8'h00};
    send_dgram();
    dgram = '{FIRST_BYTE, 8'hff};
    send_dgram();
    put_header(FIRST_BYTE, 1'b0, cur_ptype, take_seq(), cur_source);
    while (dgram.size() > 7) void'(dgram.pop_back());
    send_dgram();
    put_header(FIRST_BYTE, 1'b0, cur_ptype, 16'h1234, cur_source ^ 32'h0000_0100);
    send_dgram();
    // header only with marker: closes an empty frame
    put_header(FIRST_BYTE, 1'b1, cur_ptype, 16'h0000, cur_source);
    send_dgram();
    put_header(FIRST_BYTE, 1'b0, cur_ptype, 16'h0001, cur_source);
    dgram.push_back({3'b011, FU_TYPE});
    send_dgram();
    next_seq = 16'h0002;

    run_phase(20);
    drain();

    set_config(7'd0, 32'h0000_0000);
    hold_request = 1'b1;
    run_phase(45);
    drain();

    set_config(7'd127, 32'hffff_ffff);
    calm = 1'b1;
    run_phase(15);
    drain();
    calm = 1'b0;

    set_config(7'($urandom), $urandom);
    run_phase(15);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
